FILE: hw/rtl/u8u16_pkg.sv
// ---------------------------------------------------------------------------
// u8u16_pkg - shared types and constants for the UTF-8 to UTF-16 decoder
// Holds the result record, byte class limits and surrogate constants.
// ---------------------------------------------------------------------------
package u8u16_pkg;

    localparam int unsigned POINT_W = 21;

    localparam logic [7:0]  LEAD_MIN     = 8'hC2;
    localparam logic [7:0]  LEAD_MAX     = 8'hF4;
    localparam logic [7:0]  LEAD3_MIN    = 8'hE0;
    localparam logic [7:0]  LEAD4_MIN    = 8'hF0;
    localparam logic [1:0]  CONT_TAG     = 2'b10;

    localparam logic [POINT_W-1:0] MIN3_PREFIX = 21'h00020;
    localparam logic [POINT_W-1:0] MIN4_PREFIX = 21'h00010;
    localparam logic [POINT_W-1:0] MAX4_PREFIX = 21'h0010F;
    localparam logic [POINT_W-1:0] SUPP_BASE   = 21'h10000;
    localparam logic [POINT_W-1:0] SURR_LO     = 21'h0D800;
    localparam logic [POINT_W-1:0] SURR_HI     = 21'h0E000;

    localparam logic [15:0] HIGH_SURR = 16'hD800;
    localparam logic [15:0] LOW_SURR  = 16'hDC00;

    localparam logic [2:0]  LEN_1 = 3'd1;
    localparam logic [2:0]  LEN_4 = 3'd4;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        illegal;
        logic [2:0]  seq_length;
        logic        last;
    } result_t;

endpackage

FILE: hw/rtl/utf8_to_utf16_stream_decoder_unit.sv
// ---------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_unit - streaming UTF-8 to UTF-16 decoder
// Decodes one UTF-8 byte per transfer into zero, one or two UTF-16 units.
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  input   | in_valid / in_stall   | data_byte[7:0], end_of_input
//  output  | out_valid / out_stall | code_unit[15:0], illegal, seq_length[2:0], last
//
// One byte is taken per cycle while the input is not stalled. A byte is held in
// the input register, decoded there, and its results land in a four-entry
// result queue, from which the output side takes them.
// The input stalls only while the queue holds more than two results, which
// happens briefly after a surrogate pair or when the output side stalls.
// Reset clears the decode state, the input valid flag and the queue at once.
// ---------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        illegal,
    output logic [2:0]  seq_length,
    output logic        last
);

    localparam int unsigned PW = u8u16_pkg::POINT_W;

    // Input register
    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic       eoi_reg;

    // Decode state
    logic [PW-1:0] point_reg,  point_next;
    logic [1:0]    needed_reg, needed_next;
    logic [2:0]    seen_reg,   seen_next;

    // Result queue
    u8u16_pkg::result_t fifo_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg, count_next;

    logic in_take;
    logic advance;
    logic out_take;
    logic room;

    logic [1:0]         n_res;
    u8u16_pkg::result_t res0;
    u8u16_pkg::result_t res1;

    logic [PW-1:0] shifted;
    logic [1:0]    needed_dec;
    logic [2:0]    seen_inc;
    logic [19:0]   supp_off;
    logic          range_bad;
    logic          is_surr;

    assign room     = (count_reg <= 3'd2);
    assign advance  = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;
    assign in_take  = in_valid && !in_stall;
    assign out_valid = (count_reg != 3'd0);
    assign out_take  = out_valid && !out_stall;

    assign {code_unit, illegal, seq_length, last} = fifo_reg[rd_ptr_reg];

    assign shifted    = {point_reg[PW-7:0], byte_reg[5:0]};
    assign needed_dec = needed_reg - 2'd1;
    assign seen_inc   = seen_reg + 3'd1;
    assign supp_off   = 20'(shifted - u8u16_pkg::SUPP_BASE);
    assign is_surr    = (shifted >= u8u16_pkg::SURR_LO) && (shifted < u8u16_pkg::SURR_HI);

    // The early range check only applies to the second byte of a sequence.
    always_comb
    begin
        range_bad = 1'b0;
        if (seen_inc == 3'd2)
        begin
            if (needed_dec == 2'd1)
                range_bad = (shifted < u8u16_pkg::MIN3_PREFIX);
            else if (needed_dec == 2'd2)
                range_bad = (shifted < u8u16_pkg::MIN4_PREFIX) ||
                            (shifted > u8u16_pkg::MAX4_PREFIX);
        end
    end

    always_comb
    begin
        point_next  = point_reg;
        needed_next = needed_reg;
        seen_next   = seen_reg;
        n_res       = 2'd0;
        res0        = '{code_unit: 16'h0, illegal: 1'b1, seq_length: 3'd0, last: 1'b1};
        res1        = res0;

        if (advance)
        begin
            if (eoi_reg)
            begin
                point_next  = '0;
                needed_next = '0;
                seen_next   = '0;
                if (needed_reg != 2'd0)
                    n_res = 2'd1;
            end
            else if (needed_reg == 2'd0)
            begin
                if (!byte_reg[7])
                begin
                    n_res = 2'd1;
                    res0  = '{code_unit: {8'h0, byte_reg}, illegal: 1'b0,
                              seq_length: u8u16_pkg::LEN_1, last: 1'b1};
                end
                else if (byte_reg < u8u16_pkg::LEAD_MIN || byte_reg > u8u16_pkg::LEAD_MAX)
                begin
                    n_res = 2'd1;
                end
                else
                begin
                    seen_next = 3'd1;
                    if (byte_reg < u8u16_pkg::LEAD3_MIN)
                    begin
                        point_next  = {{(PW-5){1'b0}}, byte_reg[4:0]};
                        needed_next = 2'd1;
                    end
                    else if (byte_reg < u8u16_pkg::LEAD4_MIN)
                    begin
                        point_next  = {{(PW-4){1'b0}}, byte_reg[3:0]};
                        needed_next = 2'd2;
                    end
                    else
                    begin
                        point_next  = {{(PW-3){1'b0}}, byte_reg[2:0]};
                        needed_next = 2'd3;
                    end
                end
            end
            else if (byte_reg[7:6] != u8u16_pkg::CONT_TAG || range_bad)
            begin
                point_next  = '0;
                needed_next = '0;
                seen_next   = '0;
                n_res       = 2'd1;
            end
            else if (needed_dec != 2'd0)
            begin
                point_next  = shifted;
                needed_next = needed_dec;
                seen_next   = seen_inc;
            end
            else
            begin
                point_next  = '0;
                needed_next = '0;
                seen_next   = '0;
                if (is_surr)
                begin
                    n_res = 2'd1;
                end
                else if (shifted >= u8u16_pkg::SUPP_BASE)
                begin
                    n_res = 2'd2;
                    res0  = '{code_unit: u8u16_pkg::HIGH_SURR + {6'h0, supp_off[19:10]},
                              illegal: 1'b0, seq_length: u8u16_pkg::LEN_4, last: 1'b0};
                    res1  = '{code_unit: u8u16_pkg::LOW_SURR + {6'h0, supp_off[9:0]},
                              illegal: 1'b0, seq_length: u8u16_pkg::LEN_4, last: 1'b1};
                end
                else
                begin
                    n_res = 2'd1;
                    res0  = '{code_unit: shifted[15:0], illegal: 1'b0,
                              seq_length: seen_inc, last: 1'b1};
                end
            end
        end
    end

    assign count_next = count_reg + {1'b0, n_res} - {2'b0, out_take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            point_reg  <= '0;
            needed_reg <= '0;
            seen_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;
            point_reg  <= point_next;
            needed_reg <= needed_next;
            seen_reg   <= seen_next;
            wr_ptr_reg <= wr_ptr_reg + n_res;
            if (out_take)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= data_byte;
            eoi_reg  <= end_of_input;
        end
        if (n_res != 2'd0)
            fifo_reg[wr_ptr_reg] <= res0;
        if (n_res == 2'd2)
            fifo_reg[wr_ptr_reg + 2'd1] <= res1;
    end

endmodule

FILE: hw/rtl/u8u16_checker.sv
// ---------------------------------------------------------------------------
// u8u16_checker - port-level checks for the UTF-8 to UTF-16 decoder
// Watches the output channel and the shape of the results it carries.
// ---------------------------------------------------------------------------
module u8u16_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] code_unit,
    input logic        illegal,
    input logic [2:0]  seq_length,
    input logic        last
);

    // A result that is not last must be a high surrogate of a four-byte character.
    a_high_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> code_unit[15:10] == 6'b110110 && seq_length == 3'd4 && !illegal)
        else $error("non-final result is not a high surrogate");

    // The low surrogate is already queued, so it follows in the next cycle.
    a_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
            out_valid && last && code_unit[15:10] == 6'b110111 && seq_length == 3'd4)
        else $error("low surrogate did not follow the high surrogate");

    a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && illegal |-> code_unit == 16'h0 && seq_length == 3'd0 && last)
        else $error("illegal result carries data");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_unit) && $stable(illegal) &&
            $stable(seq_length) && $stable(last))
        else $error("stalled output transfer changed");

endmodule

bind utf8_to_utf16_stream_decoder_unit u8u16_checker u_u8u16_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_unit  (code_unit),
    .illegal    (illegal),
    .seq_length (seq_length),
    .last       (last)
);

FILE: bench/tb_utf8_to_utf16_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_utf8_to_utf16_stream_decoder_unit - self-checking bench for the decoder
// A short table of byte and end-of-input items covers the lead byte limits,
// the range checks, surrogates, truncation and bad continuation bytes. It is
// followed by random UTF-8 sequences, mostly well formed, with noise mixed
// in. A local decoder predicts the UTF-16 units of all other items, typed
// rows carry their own, and both sides of the design idle at random.
// ---------------------------------------------------------------------------
module tb_utf8_to_utf16_stream_decoder_unit;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_CYCLES = 24;
    localparam int QUIET_LO     = 900;
    localparam int QUIET_HI     = 1500;

    // Row layout: typed, one result, end of input, byte, unit, illegal, length.
    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;
    localparam logic ONE   = 1'b1;
    localparam logic NONE  = 1'b0;
    localparam logic DATA  = 1'b0;
    localparam logic STOP  = 1'b1;
    localparam logic OK    = 1'b0;
    localparam logic BAD   = 1'b1;
    localparam logic [2:0] LEN_0 = 3'd0;

    typedef struct packed {
        logic        typed;
        logic        one;
        logic        eoi;
        logic [7:0]  data;
        logic [15:0] unit;
        logic        ill;
        logic [2:0]  len;
    } stim_t;

    localparam int DIR_ROWS = 26;
    localparam logic [30:0] DIRECTED [DIR_ROWS] = '{
        {TYPED, ONE,  DATA, 8'h00, 16'h0000, OK,  u8u16_pkg::LEN_1},
        {TYPED, ONE,  DATA, 8'h7F, 16'h007F, OK,  u8u16_pkg::LEN_1},
        {TYPED, ONE,  DATA, 8'h80, 16'h0000, BAD, LEN_0},
        {TYPED, ONE,  DATA, 8'hC1, 16'h0000, BAD, LEN_0},
        {TYPED, ONE,  DATA, 8'hF5, 16'h0000, BAD, LEN_0},
        {TYPED, ONE,  DATA, 8'hFF, 16'h0000, BAD, LEN_0},
        {TYPED, NONE, STOP, 8'hA5, 16'h0000, OK,  LEN_0},
        {TYPED, NONE, DATA, 8'hC2, 16'h0000, OK,  LEN_0},
        {PRED,  NONE, DATA, 8'h80, 16'h0000, OK,  LEN_0},
        // Overlong three-byte form.
        {PRED,  NONE, DATA, 8'hE0, 16'h0000, OK,  LEN_0},
        {TYPED, ONE,  DATA, 8'h9F, 16'h0000, BAD, LEN_0},
        // Surrogate code point, caught only on the final byte.
        {PRED,  NONE, DATA, 8'hED, 16'h0000, OK,  LEN_0},
        {PRED,  NONE, DATA, 8'hA0, 16'h0000, OK,  LEN_0},
        {TYPED, ONE,  DATA, 8'h80, 16'h0000, BAD, LEN_0},
        // Overlong four-byte form, then one beyond the code space.
        {PRED,  NONE, DATA, 8'hF0, 16'h0000, OK,  LEN_0},
        {TYPED, ONE,  DATA, 8'h8F, 16'h0000, BAD, LEN_0},
        {PRED,  NONE, DATA, 8'hF4, 16'h0000, OK,  LEN_0},
        {TYPED, ONE,  DATA, 8'h90, 16'h0000, BAD, LEN_0},
        // Highest code point, a surrogate pair.
        {PRED,  NONE, DATA, 8'hF4, 16'h0000, OK,  LEN_0},
        {PRED,  NONE, DATA, 8'h8F, 16'h0000, OK,  LEN_0},
        {PRED,  NONE, DATA, 8'hBF, 16'h0000, OK,  LEN_0},
        {PRED,  NONE, DATA, 8'hBF, 16'h0000, OK,  LEN_0},
        // Truncated by end of input.
        {PRED,  NONE, DATA, 8'hE2, 16'h0000, OK,  LEN_0},
        {TYPED, ONE,  STOP, 8'h00, 16'h0000, BAD, LEN_0},
        // The bad continuation byte is consumed, not restarted.
        {PRED,  NONE, DATA, 8'hC3, 16'h0000, OK,  LEN_0},
        {TYPED, ONE,  DATA, 8'h41, 16'h0000, BAD, LEN_0}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        end_of_input;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] code_unit;
    logic        illegal;
    logic [2:0]  seq_length;
    logic        last;

    stim_t              stim_q[$];
    u8u16_pkg::result_t expected_units[$];

    logic [20:0] point_acc;
    logic [1:0]  cont_left;
    logic [2:0]  seq_seen;

    int cyc;
    int err_cnt;

    utf8_to_utf16_stream_decoder_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_unit    (code_unit),
        .illegal      (illegal),
        .seq_length   (seq_length),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit take_break();
        if (cyc >= QUIET_LO && cyc < QUIET_HI)
            return 1'b0;
        return $urandom_range(0, 99) < 28;
    endfunction

    // Decodes one accepted item against the local state.
    task automatic decode_utf8_byte(input logic [7:0] b, input logic eoi, output int n,
                                    output u8u16_pkg::result_t r0,
                                    output u8u16_pkg::result_t r1);
        logic        bad;
        logic [20:0] cp;
        logic [19:0] off;
        logic [2:0]  len;
        logic [2:0]  total;
        bad = 1'b0;
        n   = 0;
        r0  = '0;
        r1  = '0;
        if (eoi)
        begin
            bad = (cont_left != 2'd0);
            point_acc = '0;
            cont_left = '0;
            seq_seen  = '0;
        end
        else if (cont_left == 2'd0)
        begin
            if (b < 8'h80)
            begin
                r0 = {8'h00, b, 1'b0, u8u16_pkg::LEN_1, 1'b1};
                n  = 1;
            end
            else if (b < u8u16_pkg::LEAD_MIN || b > u8u16_pkg::LEAD_MAX)
                bad = 1'b1;
            else
            begin
                if (b < u8u16_pkg::LEAD3_MIN)
                begin
                    point_acc = {16'h0, b[4:0]};
                    cont_left = 2'd1;
                end
                else if (b < u8u16_pkg::LEAD4_MIN)
                begin
                    point_acc = {17'h0, b[3:0]};
                    cont_left = 2'd2;
                end
                else
                begin
                    point_acc = {18'h0, b[2:0]};
                    cont_left = 2'd3;
                end
                seq_seen = 3'd1;
            end
        end
        else if (b[7:6] != u8u16_pkg::CONT_TAG)
            bad = 1'b1;
        else
        begin
            point_acc = {point_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            seq_seen  = seq_seen + 3'd1;
            total     = {1'b0, cont_left} + 3'd2;
            if (seq_seen == 3'd2 &&
                ((total == 3'd3 && point_acc < u8u16_pkg::MIN3_PREFIX) ||
                 (total == 3'd4 && (point_acc < u8u16_pkg::MIN4_PREFIX ||
                                    point_acc > u8u16_pkg::MAX4_PREFIX))))
                bad = 1'b1;
            else if (cont_left == 2'd0)
            begin
                cp  = point_acc;
                len = seq_seen;
                point_acc = '0;
                seq_seen  = '0;
                if (cp >= u8u16_pkg::SURR_LO && cp < u8u16_pkg::SURR_HI)
                    bad = 1'b1;
                else if (cp >= u8u16_pkg::SUPP_BASE)
                begin
                    off = 20'(cp - u8u16_pkg::SUPP_BASE);
                    r0  = {u8u16_pkg::HIGH_SURR + {6'h0, off[19:10]}, 1'b0,
                           u8u16_pkg::LEN_4, 1'b0};
                    r1  = {u8u16_pkg::LOW_SURR + {6'h0, off[9:0]}, 1'b0,
                           u8u16_pkg::LEN_4, 1'b1};
                    n   = 2;
                end
                else
                begin
                    r0 = {cp[15:0], 1'b0, len, 1'b1};
                    n  = 1;
                end
            end
        end
        if (bad)
        begin
            point_acc = '0;
            cont_left = '0;
            seq_seen  = '0;
            r0 = {16'h0000, 1'b1, LEN_0, 1'b1};
            n  = 1;
        end
    endtask

    task automatic push_item(input logic eoi, input logic [7:0] b);
        stim_q.push_back({PRED, NONE, eoi, b, 16'h0000, OK, LEN_0});
    endtask

    // Encodes a code point with the given byte count, sometimes damaged.
    task automatic add_point(input logic [20:0] cp, input int len);
        logic [7:0] seq [4];
        int cut;
        int hit;
        int mode;
        case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        cut  = len;
        hit  = -1;
        mode = $urandom_range(0, 99);
        if (mode < 8)
            hit = $urandom_range(0, len - 1);
        else if (mode < 14 && len > 1)
            cut = $urandom_range(1, len - 1);
        for (int k = 0; k < cut; k++)
            push_item(DATA, (k == hit) ? 8'($urandom) : seq[k]);
        if (cut < len && $urandom_range(0, 1) == 1)
            push_item(STOP, 8'($urandom));
    endtask

    initial
    begin
        int      kind;
        int      len;
        int      n;
        int      idx;
        int      drain;
        logic [20:0] cp;
        u8u16_pkg::result_t r0;
        u8u16_pkg::result_t r1;
        u8u16_pkg::result_t got;
        u8u16_pkg::result_t want;
        stim_t   item;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = '0;
        end_of_input = 1'b0;
        out_stall    = 1'b0;
        point_acc    = '0;
        cont_left    = '0;
        seq_seen     = '0;
        cyc          = 0;
        err_cnt      = 0;

        for (int i = 0; i < DIR_ROWS; i++)
            stim_q.push_back(stim_t'(DIRECTED[i]));

        while (stim_q.size() < DIR_ROWS + RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 7)
                push_item(DATA, 8'($urandom));
            else if (kind < 10)
                push_item(STOP, 8'($urandom));
            else if (kind < 16)
            begin
                // Any value that fits the byte count: it may be overlong or out of range.
                len = $urandom_range(2, 4);
                cp  = 21'($urandom) & ((21'd1 << (len == 2 ? 11 : len == 3 ? 16 : 21)) - 21'd1);
                add_point(cp, len);
            end
            else
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1: cp = 21'($urandom_range(0, 'h7F));
                    2: cp = 21'($urandom_range('h80, 'h7FF));
                    3: cp = ($urandom_range(0, 4) == 0) ? 21'($urandom_range('hD800, 'hDFFF))
                                                        : 21'($urandom_range('h800, 'hFFFF));
                    default: cp = 21'($urandom_range('h10000, 'h10FFFF));
                endcase
                add_point(cp, len);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        idx   = 0;
        drain = 0;
        while (drain < DRAIN_CYCLES && cyc < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cyc++;

            if (in_valid && !in_stall)
            begin
                item = stim_q[idx];
                idx++;
                decode_utf8_byte(item.data, item.eoi, n, r0, r1);
                if (item.typed)
                begin
                    if (item.one)
                        expected_units.push_back({item.unit, item.ill, item.len, 1'b1});
                end
                else
                begin
                    if (n > 0)
                        expected_units.push_back(r0);
                    if (n > 1)
                        expected_units.push_back(r1);
                end
            end

            if (out_valid && !out_stall)
            begin
                got = {code_unit, illegal, seq_length, last};
                if (expected_units.size() == 0)
                begin
                    $error("unexpected result transfer: code_unit %h illegal %b",
                           got.code_unit, got.illegal);
                    err_cnt++;
                end
                else
                begin
                    want = expected_units.pop_front();
                    if (got.code_unit !== want.code_unit)
                    begin
                        $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
                        err_cnt++;
                    end
                    if (got.illegal !== want.illegal)
                    begin
                        $error("illegal: expected %b, got %b", want.illegal, got.illegal);
                        err_cnt++;
                    end
                    if (got.seq_length !== want.seq_length)
                    begin
                        $error("seq_length: expected %0d, got %0d",
                               want.seq_length, got.seq_length);
                        err_cnt++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, got.last);
                        err_cnt++;
                    end
                end
            end

            // A stalled transfer keeps its payload until it is taken.
            if (!(in_valid && in_stall))
            begin
                if (idx < stim_q.size() && !take_break())
                begin
                    in_valid     <= 1'b1;
                    data_byte    <= stim_q[idx].data;
                    end_of_input <= stim_q[idx].eoi;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= take_break();

            if (idx == stim_q.size() && expected_units.size() == 0)
                drain++;
            else
                drain = 0;
        end

        if (drain < DRAIN_CYCLES || err_cnt != 0 || expected_units.size() != 0)
            $display("Regression FAIL");
        else
            $display("Regression PASS");
        $finish;
    end

endmodule
